// ===== design/kskf_pkg.sv =====
// ----------------------------------------------------------------------------
// kskf_pkg
// Types and constants shared by the scalar speed filter modules.
// ----------------------------------------------------------------------------
package kskf_pkg;

  localparam int SPEED_W = 24;
  localparam int VAR_W   = 32;
  localparam int GAIN_W  = 17;
  localparam int NOISE_W = 16;
  localparam int Q_BITS  = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int MUL_W = 32;

  localparam logic [NOISE_W-1:0] NOISE_RESET = 16'd32768;
  localparam logic [VAR_W-1:0]   INIT_ERROR_RESET = 32'd655360;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ERROR = 4'd1;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_RESET  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [SPEED_W-1:0] measurement;
    logic [VAR_W-1:0]   meas_variance;
  } item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_estimate;
    logic [VAR_W-1:0]   error_variance;
    logic [GAIN_W-1:0]  gain;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_STEP,
    ST_UPD_X,
    ST_MUL_NOISE,
    ST_SUM,
    ST_DONE
  } state_t;

endpackage

// ===== design/scalar_kalman_speed_filter.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_speed_filter
// Scalar Kalman filter for a fixed-point speed signal.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): one beat per item, an
//   update (measurement z, variance r) or a filter reset.
//   result channel (result_valid / result_stall / result): one beat per item
//   with the new estimate, error variance and the gain used.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready;
//   index 0 is process_noise, index 1 is initial_error, others are ignored.
// Timing:
//   an update passes the gain divider, one quotient bit per cycle, and then
//   makes three passes through the shared multiplier; a reset item skips both
//   and goes straight to the done state.
//   item_stall is high while an item is in work; one item at a time.
// Reset: rst clears the estimate, loads the error variance and registers
//   with their reset values and drops result_valid.
// Stall: a finished result waits in the output register; the block takes a
//   new item meanwhile, but holds its next result until the register frees.
// ----------------------------------------------------------------------------
module scalar_kalman_speed_filter
  import kskf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int GW = FRAC_BITS + 1;
  localparam logic [GW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  state_t state, state_next;

  logic [NOISE_W-1:0] process_noise;
  logic [VAR_W-1:0]   initial_error;
  logic [SPEED_W-1:0] estimate_reg;
  logic [VAR_W-1:0]   error_reg;
  logic [SPEED_W-1:0] meas;
  logic [GW-1:0]      gain;
  logic [SPEED_W-1:0] diff;
  logic               up;
  logic [VAR_W-1:0]   term;

  logic               accept;
  logic               div_start;
  logic               div_done;
  logic [GW-1:0]      div_q;
  logic [VAR_W:0]     div_denom;
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [2*MUL_W-1:0] mul_p;
  logic [SPEED_W-1:0] step;
  logic [VAR_W:0]     pn;
  logic               out_free;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign div_start  = accept && (item.operation == OP_UPDATE);
  assign div_denom  = {1'b0, error_reg} + {1'b0, item.meas_variance};
  assign step       = SPEED_W'(mul_p >> FRAC_BITS);
  assign pn         = {1'b0, term} + (VAR_W + 1)'(mul_p >> Q_BITS);

  kskf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (error_reg),
    .denom    (div_denom),
    .done     (div_done),
    .quotient (div_q)
  );

  kskf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (item.operation == OP_RESET) ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_MUL_STEP;
        end
      end
      ST_MUL_STEP: begin
        mul_a      = MUL_W'(gain);
        mul_b      = MUL_W'(diff);
        state_next = ST_UPD_X;
      end
      ST_UPD_X: begin
        mul_a      = MUL_W'(ONE - gain);
        mul_b      = error_reg;
        state_next = ST_MUL_NOISE;
      end
      ST_MUL_NOISE: begin
        mul_a      = MUL_W'(estimate_reg);
        mul_b      = MUL_W'(process_noise);
        state_next = ST_SUM;
      end
      ST_SUM: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise <= NOISE_RESET;
      initial_error <= INIT_ERROR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_PROCESS_NOISE) begin
        process_noise <= cfg_data[NOISE_W-1:0];
      end else if (cfg_index == REG_INITIAL_ERROR) begin
        initial_error <= cfg_data[VAR_W-1:0];
      end
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      estimate_reg <= '0;
      error_reg    <= INIT_ERROR_RESET;
    end else if (accept && item.operation == OP_RESET) begin
      estimate_reg <= '0;
      error_reg    <= initial_error;
    end else if (state == ST_UPD_X) begin
      estimate_reg <= up ? (estimate_reg + step) : (estimate_reg - step);
    end else if (state == ST_SUM) begin
      error_reg <= pn[VAR_W] ? '1 : pn[VAR_W-1:0];
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      meas <= item.measurement;
      gain <= '0;
    end
    if (state == ST_DIV && div_done) begin
      gain <= div_q;
      up   <= meas >= estimate_reg;
      diff <= (meas >= estimate_reg) ? (meas - estimate_reg) : (estimate_reg - meas);
    end
    if (state == ST_MUL_NOISE) begin
      term <= VAR_W'(mul_p >> FRAC_BITS);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      result.speed_estimate <= estimate_reg;
      result.error_variance <= error_reg;
      result.gain           <= GAIN_W'(gain);
    end
  end

endmodule

// ===== design/kskf_div.sv =====
// ----------------------------------------------------------------------------
// kskf_div
// Radix-2 restoring divider for the gain: (p << FRAC_BITS) / (p + r), one
// quotient bit per cycle, quotient 0 for a zero divisor.
// ----------------------------------------------------------------------------
module kskf_div
  import kskf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [VAR_W-1:0]     numer,
  input  logic [VAR_W:0]       denom,
  output logic                 done,
  output logic [FRAC_BITS:0]   quotient
);

  localparam int GW = FRAC_BITS + 1;
  localparam int CW = $clog2(GW);
  localparam int RW = VAR_W + 2;

  logic [RW-1:0]    rem;
  logic [VAR_W:0]   div;
  logic [GW-1:0]    quo;
  logic [CW-1:0]    count;
  logic             busy;
  logic             zero_div;
  logic             ge;
  logic [RW-1:0]    diff;

  assign ge   = rem >= RW'(div);
  assign diff = ge ? (rem - RW'(div)) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CW'(GW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= RW'(numer);
      div      <= denom;
      quo      <= '0;
      zero_div <= (denom == '0);
    end else if (busy) begin
      rem <= diff << 1;
      quo <= {quo[GW-2:0], ge};
    end
  end

  assign quotient = zero_div ? '0 : quo;

endmodule

// ===== design/kskf_mul.sv =====
// ----------------------------------------------------------------------------
// kskf_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module kskf_mul
  import kskf_pkg::*;
(
  input  logic                 clk,
  input  logic [MUL_W-1:0]     a,
  input  logic [MUL_W-1:0]     b,
  output logic [2*MUL_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== design/kskf_checker.sv =====
// ----------------------------------------------------------------------------
// kskf_port_checks
// Port-level checks for the scalar speed filter, bound to the top level.
// ----------------------------------------------------------------------------
module kskf_port_checks
  import kskf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // held beat stays up
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  // held beat keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("result payload changed while stalled");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item taken while previous item in work");

  // gain never above one (checked for FRAC_BITS up to 16)
  a_gain: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (FRAC_BITS > 16) || (result.gain <= (GAIN_W'(1) << FRAC_BITS)))
    else $error("gain above one");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result beat right after reset");

endmodule

bind scalar_kalman_speed_filter kskf_port_checks #(.FRAC_BITS(FRAC_BITS)) u_kskf_checker (.*);
